// ===== sv/perlin_noise_2d_unit_macros.svh =====
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit_macros.svh
// Assertion macros shared by the noise unit RTL
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_2D_UNIT_MACROS_SVH
`define PERLIN_NOISE_2D_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PN2D_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PN2D_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/pn2d_pkg.sv =====
// ----------------------------------------------------------------------------
// pn2d_pkg
// Constants shared by the 2D gradient noise unit and its channel interfaces
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pn2d_pkg;

	// default number of fraction bits on coordinates and result
	localparam int FRAC_BITS_DEF = 16;

	// coordinate width
	localparam int COORD_W = 32;

	// corner hash multipliers and xorshift amounts
	localparam logic [COORD_W-1:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [COORD_W-1:0] HASH_MUL_Y   = 32'd668265263;
	localparam logic [COORD_W-1:0] HASH_MUL_MIX = 32'd1274126177;
	localparam int                 HASH_SHIFT_A = 13;
	localparam int                 HASH_SHIFT_B = 16;

	// quintic fade polynomial 6t^2 - 15t + 10 (times t^3)
	localparam int FADE_K2 = 6;
	localparam int FADE_K1 = 15;
	localparam int FADE_K0 = 10;

	// gradient select codes
	localparam logic [3:0] GRAD_U_Y_FROM = 4'd8;
	localparam logic [3:0] GRAD_V_X_FROM = 4'd4;
	localparam logic [3:0] GRAD_V_X_A    = 4'd12;
	localparam logic [3:0] GRAD_V_X_B    = 4'd14;

endpackage

// ===== sv/pn2d_in_if.sv =====
// ----------------------------------------------------------------------------
// pn2d_in_if
// Sample point channel: valid/ready with signed fixed point x and y
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pn2d_in_if;
	import pn2d_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;

	modport source (output valid, output coord_x, output coord_y, input ready);
	modport sink   (input valid, input coord_x, input coord_y, output ready);

endinterface

// ===== sv/pn2d_out_if.sv =====
// ----------------------------------------------------------------------------
// pn2d_out_if
// Noise result channel: valid/ready with a signed fixed point value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pn2d_out_if #(
	parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
);
	import pn2d_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [FRAC_BITS+2:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink   (input valid, input noise_value, output ready);

endinterface

// ===== sv/perlin_noise_2d_unit.sv =====
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit
// 2D gradient noise, one sample point in and one noise value out per cycle
// while result.ready holds. The unit is a six-stage register pipeline and
// takes a new sample every cycle unless it is full and stalled. Stage 1
// floors the point and runs the two coordinate hash multiplies, stage 2 sums
// the four corner keys and builds the fade polynomial, stage 3 runs the four
// hash mix multiplies, stage 4 picks the gradients and finishes the fade,
// stages 5 and 6 blend along x and then y. Each stage holds its item while
// the next one is full and stalled, so empty stages still take new samples
// when the result side holds off. Coordinates and the result carry FRAC_BITS
// fraction bits; the result interface must be built with the same FRAC_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perlin_noise_2d_unit_macros.svh"

module perlin_noise_2d_unit #(
	parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pn2d_in_if.sink    sample,
	pn2d_out_if.source result
);
	import pn2d_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int OFSW = F + 2;        // corner-relative offset, signed
	localparam int TW   = F + 3;        // gradient term and result, signed
	localparam int PW2  = 2 * F + 5;    // exact fade polynomial
	localparam int PW   = F + 4;        // truncated fade polynomial
	localparam int UPW  = 2 * F + 4;    // fade final product
	localparam int MW   = 2 * F + 6;    // blend products and sum

	localparam logic [F:0]             ONE_W   = {1'b1, {F{1'b0}}};
	localparam logic signed [OFSW-1:0] OFS_ONE = {2'b01, {F{1'b0}}};
	localparam logic [COORD_W-1:0]     HASH_MUL_XY = HASH_MUL_X + HASH_MUL_Y;

	// gradient of one corner: (+/-u) + (+/-v) picked by the hash nibble
	function automatic logic signed [TW-1:0] grad_term(
		input logic [3:0]             g,
		input logic signed [OFSW-1:0] x,
		input logic signed [OFSW-1:0] y
	);
		logic signed [TW-1:0] u;
		logic signed [TW-1:0] v;
		u = (g < GRAD_U_Y_FROM) ? TW'(x) : TW'(y);
		if (g < GRAD_V_X_FROM) begin
			v = TW'(y);
		end else if (g inside {GRAD_V_X_A, GRAD_V_X_B}) begin
			v = TW'(x);
		end else begin
			v = '0;
		end
		if (g[0]) u = -u;
		if (g[1]) v = -v;
		return u + v;
	endfunction

	// stage valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	assign adv_s6 = !v_s6 || result.ready;
	assign adv_s5 = !v_s5 || adv_s6;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;

	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= sample.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: floor to cell, coordinate hash multiplies, fraction squares
	logic [COORD_W-1:0] cell_x, cell_y;
	logic [F-1:0]       frac_x, frac_y;
	logic [COORD_W-1:0] mx_s1, my_s1;
	logic [2*F-1:0]     sqx_s1, sqy_s1;
	logic [F-1:0]       fx_s1, fy_s1;

	assign cell_x = COORD_W'(sample.coord_x >>> F);
	assign cell_y = COORD_W'(sample.coord_y >>> F);
	assign frac_x = sample.coord_x[F-1:0];
	assign frac_y = sample.coord_y[F-1:0];

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mx_s1  <= cell_x * HASH_MUL_X;
			my_s1  <= cell_y * HASH_MUL_Y;
			sqx_s1 <= (2*F)'(frac_x) * (2*F)'(frac_x);
			sqy_s1 <= (2*F)'(frac_y) * (2*F)'(frac_y);
			fx_s1  <= frac_x;
			fy_s1  <= frac_y;
		end
	end

	// stage 2: corner keys with first xorshift, fade polynomial
	logic [COORD_W-1:0] key_sum;
	logic [COORD_W-1:0] key [4];
	logic [COORD_W-1:0] mix_s2 [4];
	logic [PW2-1:0]     px2, py2;
	logic [PW-1:0]      px_s2, py_s2;
	logic [F-1:0]       w1x_s2, w1y_s2;
	logic [F-1:0]       fx_s2, fy_s2;

	assign key_sum = mx_s1 + my_s1;
	assign key[0]  = key_sum;
	assign key[1]  = key_sum + HASH_MUL_X;
	assign key[2]  = key_sum + HASH_MUL_Y;
	assign key[3]  = key_sum + HASH_MUL_XY;

	assign px2 = PW2'(FADE_K2) * PW2'(sqx_s1) + (PW2'(FADE_K0) << (2 * F))
		- ((PW2'(FADE_K1) * PW2'(fx_s1)) << F);
	assign py2 = PW2'(FADE_K2) * PW2'(sqy_s1) + (PW2'(FADE_K0) << (2 * F))
		- ((PW2'(FADE_K1) * PW2'(fy_s1)) << F);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int k = 0; k < 4; k++) begin
				mix_s2[k] <= key[k] ^ (key[k] >> HASH_SHIFT_A);
			end
			px_s2  <= px2[2*F+3:F];
			py_s2  <= py2[2*F+3:F];
			w1x_s2 <= sqx_s1[2*F-1:F];
			w1y_s2 <= sqy_s1[2*F-1:F];
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
		end
	end

	// stage 3: hash mix multiplies, cube of the fraction
	logic [COORD_W-1:0] hmul [4];
	logic [COORD_W-1:0] hval [4];
	logic [3:0]         g_s3 [4];
	logic [2*F-1:0]     cbx, cby;
	logic [F-1:0]       w2x_s3, w2y_s3;
	logic [PW-1:0]      px_s3, py_s3;
	logic [F-1:0]       fx_s3, fy_s3;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			hmul[k] = mix_s2[k] * HASH_MUL_MIX;
			hval[k] = hmul[k] ^ (hmul[k] >> HASH_SHIFT_B);
		end
	end

	assign cbx = (2*F)'(w1x_s2) * (2*F)'(fx_s2);
	assign cby = (2*F)'(w1y_s2) * (2*F)'(fy_s2);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			for (int k = 0; k < 4; k++) begin
				g_s3[k] <= hval[k][3:0];
			end
			w2x_s3 <= cbx[2*F-1:F];
			w2y_s3 <= cby[2*F-1:F];
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
		end
	end

	// stage 4: fade weights, gradient terms at the four corners
	logic [UPW-1:0]             upx, upy;
	logic signed [OFSW-1:0]     ox0, ox1, oy0, oy1;
	logic [F:0]                 ux_s4, uy_s4;
	logic signed [TW-1:0]       n_s4 [4];

	assign upx = UPW'(w2x_s3) * UPW'(px_s3);
	assign upy = UPW'(w2y_s3) * UPW'(py_s3);

	assign ox0 = $signed({2'b00, fx_s3});
	assign oy0 = $signed({2'b00, fy_s3});
	assign ox1 = ox0 - OFS_ONE;
	assign oy1 = oy0 - OFS_ONE;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			ux_s4   <= upx[2*F:F];
			uy_s4   <= upy[2*F:F];
			n_s4[0] <= grad_term(g_s3[0], ox0, oy0);
			n_s4[1] <= grad_term(g_s3[1], ox1, oy0);
			n_s4[2] <= grad_term(g_s3[2], ox0, oy1);
			n_s4[3] <= grad_term(g_s3[3], ox1, oy1);
		end
	end

	// stage 5: blend along x for both rows
	logic [F:0]           wx0;
	logic signed [MW-1:0] bx0, bx1;
	logic signed [TW-1:0] a0_s5, a1_s5;
	logic [F:0]           uy_s5;

	assign wx0 = ONE_W - ux_s4;
	assign bx0 = MW'(n_s4[0]) * MW'($signed({1'b0, wx0}))
		+ MW'(n_s4[1]) * MW'($signed({1'b0, ux_s4}));
	assign bx1 = MW'(n_s4[2]) * MW'($signed({1'b0, wx0}))
		+ MW'(n_s4[3]) * MW'($signed({1'b0, ux_s4}));

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			a0_s5 <= TW'(bx0 >>> F);
			a1_s5 <= TW'(bx1 >>> F);
			uy_s5 <= uy_s4;
		end
	end

	// stage 6: blend along y, output register
	logic [F:0]           wy0;
	logic signed [MW-1:0] by;
	logic signed [TW-1:0] res_s6;

	assign wy0 = ONE_W - uy_s5;
	assign by  = MW'(a0_s5) * MW'($signed({1'b0, wy0}))
		+ MW'(a1_s5) * MW'($signed({1'b0, uy_s5}));

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			res_s6 <= TW'(by >>> F);
		end
	end

	assign result.valid       = v_s6;
	assign result.noise_value = res_s6;

	// checks
	`PN2D_ASSERT_NOW(a_empty_entry_ready, !v_s1, sample.ready, "stage 1 empty but sample not ready")
	`PN2D_ASSERT_NEXT(a_accept_fills_s1, sample.valid && sample.ready, v_s1, "accepted sample lost")
	`PN2D_ASSERT_NOW(a_full_blocks_input, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !result.ready, !sample.ready, "sample taken into a full stalled pipe")
	`PN2D_ASSERT_NOW(a_fade_in_range, v_s4, (ux_s4 <= ONE_W) && (uy_s4 <= ONE_W), "fade weight above one")

endmodule
